>>> hw/rtl/prc_pkg.sv
package prc_pkg;

    localparam int CountBitsDefault = 16;
    localparam int AccW             = 50;   // camera coordinate, Q.30, signed
    localparam int QuotBits         = 33;   // quotient bits of the projection
    localparam int QuotCntW         = 6;
    localparam int FracBits         = 28;
    localparam int CfgIdxW          = 3;
    localparam int CfgDataW         = 48;
    localparam int TotalW           = 16;

    localparam logic [CfgIdxW-1:0] RegRot0  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegRot1  = 3'd1;
    localparam logic [CfgIdxW-1:0] RegRot2  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegTx    = 3'd3;
    localparam logic [CfgIdxW-1:0] RegTy    = 3'd4;
    localparam logic [CfgIdxW-1:0] RegTz    = 3'd5;
    localparam logic [CfgIdxW-1:0] RegLimit = 3'd6;

    typedef struct packed {
        logic       load;
        logic       mac;
        logic [1:0] row;
        logic [1:0] col;
        logic       setup;
        logic       div;
        logic       mag;
        logic       sq_first;
        logic       sq_second;
        logic       finish;
    } prc_cmd_t;

    typedef struct packed {
        logic zpos;
        logic out_free;
    } prc_status_t;

endpackage

>>> hw/rtl/prc_ctrl.sv
module prc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  prc_pkg::prc_status_t status,
    output prc_pkg::prc_cmd_t    cmd
);
    import prc_pkg::*;

    typedef enum logic [2:0] {
        IDLE, MAC, SETUP, DIV, MAG, SQ0, SQ1, FIN
    } state_t;

    state_t                state_reg;
    logic [1:0]            row_reg;
    logic [1:0]            col_reg;
    logic [QuotCntW-1:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            row_reg   <= 2'd0;
            col_reg   <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    row_reg <= 2'd0;
                    col_reg <= 2'd0;
                    if (in_valid)
                        state_reg <= MAC;
                end
                MAC:
                begin
                    if (col_reg == 2'd2)
                    begin
                        col_reg <= 2'd0;
                        row_reg <= row_reg + 2'd1;
                        if (row_reg == 2'd2)
                            state_reg <= SETUP;
                    end
                    else
                        col_reg <= col_reg + 2'd1;
                end
                SETUP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= status.zpos ? DIV : FIN;
                end
                DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == QuotCntW'(QuotBits - 1))
                        state_reg <= MAG;
                end
                MAG:     state_reg <= SQ0;
                SQ0:     state_reg <= SQ1;
                SQ1:     state_reg <= FIN;
                FIN:
                begin
                    if (status.out_free)
                        state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign in_stall = (state_reg != IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.row       = row_reg;
        cmd.col       = col_reg;
        cmd.load      = (state_reg == IDLE) && in_valid;
        cmd.mac       = (state_reg == MAC);
        cmd.setup     = (state_reg == SETUP);
        cmd.div       = (state_reg == DIV);
        cmd.mag       = (state_reg == MAG);
        cmd.sq_first  = (state_reg == SQ0);
        cmd.sq_second = (state_reg == SQ1);
        cmd.finish    = (state_reg == FIN) && status.out_free;
    end

endmodule

>>> hw/rtl/prc_datapath.sv
module prc_datapath #(
    parameter int COUNT_BITS = prc_pkg::CountBitsDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [prc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [prc_pkg::CfgDataW-1:0]  cfg_data,
    input  logic signed [31:0]            point_x,
    input  logic signed [31:0]            point_y,
    input  logic signed [31:0]            point_z,
    input  logic signed [31:0]            obs_u,
    input  logic signed [31:0]            obs_v,
    input  logic                          last_point,
    input  prc_pkg::prc_cmd_t             cmd,
    output prc_pkg::prc_status_t          status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          is_inlier,
    output logic [prc_pkg::TotalW-1:0]    inlier_total,
    output logic                          set_done
);
    import prc_pkg::*;

    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    // configuration
    logic [47:0]        rot0_reg, rot1_reg, rot2_reg;
    logic signed [31:0] tx_reg, ty_reg, tz_reg;
    logic [31:0]        lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot0_reg <= '0;
            rot1_reg <= '0;
            rot2_reg <= '0;
            tx_reg   <= '0;
            ty_reg   <= '0;
            tz_reg   <= '0;
            lim_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegRot0:  rot0_reg <= cfg_data;
                RegRot1:  rot1_reg <= cfg_data;
                RegRot2:  rot2_reg <= cfg_data;
                RegTx:    tx_reg   <= cfg_data[31:0];
                RegTy:    ty_reg   <= cfg_data[31:0];
                RegTz:    tz_reg   <= cfg_data[31:0];
                RegLimit: lim_reg  <= cfg_data[31:0];
                default:  ;
            endcase
        end
    end

    // item payload
    logic signed [31:0] px_reg, py_reg, pz_reg, ou_reg, ov_reg;
    logic               last_reg;

    // camera coordinates
    logic signed [AccW-1:0] ax_reg, ay_reg, az_reg;
    logic [47:0]            row_sel;
    logic signed [15:0]     coef;
    logic signed [31:0]     pt_sel;
    logic signed [47:0]     prod;
    logic signed [AccW-1:0] prod_ext;

    always_comb
    begin
        case (cmd.row)
            2'd0:    row_sel = rot0_reg;
            2'd1:    row_sel = rot1_reg;
            default: row_sel = rot2_reg;
        endcase
        case (cmd.col)
            2'd0:
            begin
                coef   = row_sel[15:0];
                pt_sel = px_reg;
            end
            2'd1:
            begin
                coef   = row_sel[31:16];
                pt_sel = py_reg;
            end
            default:
            begin
                coef   = row_sel[47:32];
                pt_sel = pz_reg;
            end
        endcase
        prod     = coef * pt_sel;
        prod_ext = AccW'(prod);
    end

    // projection divider, x and y lanes share the depth divisor
    logic [AccW-1:0]     ux, uy, ud;
    logic                sx_reg, sy_reg, satx_reg, saty_reg, zpos_reg;
    logic [AccW-1:0]     rx_reg, ry_reg;
    logic [QuotBits-1:0] nbx_reg, nby_reg, qx_reg, qy_reg;
    logic [AccW:0]       trx, try_;
    logic                gex, gey;

    assign ux  = ax_reg[AccW-1] ? AccW'(-ax_reg) : AccW'(ax_reg);
    assign uy  = ay_reg[AccW-1] ? AccW'(-ay_reg) : AccW'(ay_reg);
    assign ud  = az_reg;
    assign trx = {rx_reg, nbx_reg[QuotBits-1]};
    assign try_ = {ry_reg, nby_reg[QuotBits-1]};
    assign gex = (trx >= {1'b0, ud});
    assign gey = (try_ >= {1'b0, ud});

    // error terms
    logic [QuotBits:0]     qmx, qmy;
    logic signed [35:0]    qsx, qsy, dxu, dyv, du_abs, dv_abs;
    logic [31:0]           mu_reg, mv_reg;
    logic [63:0]           p_reg, err_reg, sq_v;
    logic                  hit;

    always_comb
    begin
        qmx    = satx_reg ? (QuotBits+1)'(1) << QuotBits : {1'b0, qx_reg};
        qmy    = saty_reg ? (QuotBits+1)'(1) << QuotBits : {1'b0, qy_reg};
        qsx    = sx_reg ? -36'(qmx) : 36'(qmx);
        qsy    = sy_reg ? -36'(qmy) : 36'(qmy);
        dxu    = qsx - 36'(ou_reg);
        dyv    = qsy - 36'(ov_reg);
        du_abs = dxu[35] ? -dxu : dxu;
        dv_abs = dyv[35] ? -dyv : dyv;
        sq_v   = mv_reg * mv_reg;
        hit    = zpos_reg && (err_reg < {lim_reg, FracBits'(0)});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg   <= point_x;
            py_reg   <= point_y;
            pz_reg   <= point_z;
            ou_reg   <= obs_u;
            ov_reg   <= obs_v;
            last_reg <= last_point;
            ax_reg   <= AccW'(tx_reg) <<< 14;
            ay_reg   <= AccW'(ty_reg) <<< 14;
            az_reg   <= AccW'(tz_reg) <<< 14;
        end
        if (cmd.mac)
        begin
            case (cmd.row)
                2'd0:    ax_reg <= ax_reg + prod_ext;
                2'd1:    ay_reg <= ay_reg + prod_ext;
                default: az_reg <= az_reg + prod_ext;
            endcase
        end
        if (cmd.setup)
        begin
            zpos_reg <= status.zpos;
            sx_reg   <= ax_reg[AccW-1];
            sy_reg   <= ay_reg[AccW-1];
            satx_reg <= ({5'd0, ux} >= {ud, 5'd0});
            saty_reg <= ({5'd0, uy} >= {ud, 5'd0});
            rx_reg   <= ux >> 5;
            ry_reg   <= uy >> 5;
            nbx_reg  <= {ux[4:0], FracBits'(0)};
            nby_reg  <= {uy[4:0], FracBits'(0)};
            qx_reg   <= '0;
            qy_reg   <= '0;
        end
        if (cmd.div)
        begin
            rx_reg  <= gex ? AccW'(trx - {1'b0, ud}) : AccW'(trx);
            ry_reg  <= gey ? AccW'(try_ - {1'b0, ud}) : AccW'(try_);
            qx_reg  <= {qx_reg[QuotBits-2:0], gex};
            qy_reg  <= {qy_reg[QuotBits-2:0], gey};
            nbx_reg <= nbx_reg << 1;
            nby_reg <= nby_reg << 1;
        end
        if (cmd.mag)
        begin
            // clamp large terms: they already exceed any limit
            mu_reg <= (du_abs > 36'sh80000000) ? 32'h80000000 : du_abs[31:0];
            mv_reg <= (dv_abs > 36'sh80000000) ? 32'h80000000 : dv_abs[31:0];
        end
        if (cmd.sq_first)
            p_reg <= mu_reg * mu_reg;
        if (cmd.sq_second)
            err_reg <= p_reg + sq_v;
    end

    assign status.zpos = !az_reg[AccW-1] && (az_reg != '0);

    // counter and output register
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [32:0]           cnt_wide;
    logic                  out_valid_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (hit && (cnt_reg != CountMax))
            cnt_next = cnt_reg + 1'b1;
        cnt_wide = 33'(cnt_next);
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= last_reg ? '0 : cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            is_inlier    <= hit;
            set_done     <= last_reg;
            inlier_total <= (cnt_wide > 33'd65535) ? 16'hFFFF : cnt_wide[15:0];
        end
    end

endmodule

>>> hw/rtl/pose_reprojection_inlier_counter_top.sv
// Scores world points against a configured camera pose. Each item passes from
// acceptance to result through the camera transform on one shared 16x32
// multiplier, setup, the restoring divider that projects x and y by depth, the
// squared error and the count. A point with non-positive depth skips the divider
// and the squared error. The next item is accepted once the controller has
// returned to idle after the result is registered. One item is in work at a
// time; the result sits in an output register, so the next item can start while
// it waits. The inlier count saturates and clears after an item marked
// last_point. Configuration is written through cfg_* only while the block is
// idle; the user must keep to this, as the block itself does not enforce it.
module pose_reprojection_inlier_counter_top #(
    parameter int COUNT_BITS = prc_pkg::CountBitsDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [prc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [prc_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [31:0]            point_x,
    input  logic signed [31:0]            point_y,
    input  logic signed [31:0]            point_z,
    input  logic signed [31:0]            obs_u,
    input  logic signed [31:0]            obs_v,
    input  logic                          last_point,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          is_inlier,
    output logic [prc_pkg::TotalW-1:0]    inlier_total,
    output logic                          set_done
);
    import prc_pkg::*;

    prc_cmd_t    cmd;
    prc_status_t status;

    assign cfg_ready = 1'b1;

    prc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    prc_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .obs_u        (obs_u),
        .obs_v        (obs_v),
        .last_point   (last_point),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_inlier    (is_inlier),
        .inlier_total (inlier_total),
        .set_done     (set_done)
    );

endmodule
